### hdl/pnmhp_pkg.sv
// ----------------------------------------------------------------------------
// pnmhp_pkg
// Shared widths, character codes, error codes and the result word layout
// for the binary PNM header parser.
// ----------------------------------------------------------------------------
package pnmhp_pkg;

    localparam int DIM_BITS   = 16;
    localparam int COUNT_BITS = 12;

    localparam logic [7:0] CH_P     = 8'h50;  // 'P'
    localparam logic [7:0] CH_5     = 8'h35;  // '5'
    localparam logic [7:0] CH_6     = 8'h36;  // '6'
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam int TWO_BYTE_MIN = 256;

    typedef enum logic [2:0] {
        ERR_OK    = 3'd0,
        ERR_NO_P  = 3'd1,
        ERR_TYPE  = 3'd2,
        ERR_TRUNC = 3'd3,
        ERR_OVF   = 3'd4
    } err_t;

    typedef struct packed {
        err_t                  error_code;
        logic [DIM_BITS-1:0]   image_width;
        logic [DIM_BITS-1:0]   image_height;
        logic [DIM_BITS-1:0]   max_value;
        logic [1:0]            plane_count;
        logic [1:0]            bytes_per_value;
        logic [COUNT_BITS-1:0] header_length;
    } res_t;

endpackage

### hdl/pnmhp_core.sv
// ----------------------------------------------------------------------------
// pnmhp_core
// Header parse state and its update per byte. Raises
// res_valid with the result word when the header ends or an error is found.
// ----------------------------------------------------------------------------
module pnmhp_core
    import pnmhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    output logic       res_valid,
    output res_t       res
);

    typedef enum logic [8:0] {
        PH_MAGIC_P = 9'b000000001,
        PH_MAGIC_T = 9'b000000010,
        PH_SKIP_W  = 9'b000000100,
        PH_NUM_W   = 9'b000001000,
        PH_SKIP_H  = 9'b000010000,
        PH_NUM_H   = 9'b000100000,
        PH_SKIP_M  = 9'b001000000,
        PH_NUM_M   = 9'b010000000,
        PH_TO_EOL  = 9'b100000000
    } phase_t;

    phase_t                phase_reg,   phase_next;
    logic                  comment_reg, comment_next;
    logic [DIM_BITS-1:0]   width_reg,   width_next;
    logic [DIM_BITS-1:0]   height_reg,  height_next;
    logic [DIM_BITS-1:0]   maxval_reg,  maxval_next;
    logic                  color_reg,   color_next;
    logic                  ovf_reg,     ovf_next;
    logic [COUNT_BITS-1:0] count_reg,   count_next;

    logic                  is_digit;
    logic                  is_space;
    logic                  is_lf;
    logic                  is_hash;
    logic [DIM_BITS-1:0]   mac_in;
    logic [DIM_BITS+3:0]   mac_full;
    logic                  mac_ovf;
    logic [DIM_BITS-1:0]   mac_val;
    logic [DIM_BITS-1:0]   digit_val;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  emit;
    err_t                  err;
    // skip-phase outcome
    logic                  skip_take_num;
    logic                  skip_junk;

    assign is_digit  = in_byte inside {[CH_0:CH_9]};
    assign is_lf     = (in_byte == CH_LF);
    assign is_space  = in_byte inside {CH_SPACE, CH_CR, CH_LF};
    assign is_hash   = (in_byte == CH_HASH);
    assign digit_val = DIM_BITS'(in_byte[3:0]);

    // one shared multiply-add by ten
    assign mac_in   = (phase_reg == PH_NUM_W) ? width_reg :
                      (phase_reg == PH_NUM_H) ? height_reg : maxval_reg;
    assign mac_full = ({4'b0, mac_in} << 3) + ({4'b0, mac_in} << 1)
                      + {4'b0, digit_val};
    assign mac_ovf  = |mac_full[DIM_BITS+3:DIM_BITS];
    assign mac_val  = mac_ovf ? {DIM_BITS{1'b1}} : mac_full[DIM_BITS-1:0];

    assign count_inc = (&count_reg) ? count_reg : count_reg + 1'b1;

    assign skip_take_num = !comment_reg && !is_space && !is_hash && is_digit;
    assign skip_junk     = !comment_reg && !is_space && !is_hash && !is_digit;

    always_comb
    begin
        phase_next   = phase_reg;
        comment_next = comment_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        maxval_next  = maxval_reg;
        color_next   = color_reg;
        ovf_next     = ovf_reg;
        count_next   = count_reg;
        emit         = 1'b0;
        err          = ERR_OK;

        if (fire)
        begin
            if (end_of_input)
            begin
                emit = 1'b1;
                err  = (phase_reg inside {PH_NUM_M, PH_TO_EOL}) ? ERR_OK : ERR_TRUNC;
            end
            else
            begin
                count_next = count_inc;
                // a comment only ends on LF; '#' opens one outside a comment
                if (comment_reg && is_lf)
                    comment_next = 1'b0;
                case (phase_reg)
                    PH_MAGIC_P:
                    begin
                        if (in_byte != CH_P)
                        begin
                            emit = 1'b1;
                            err  = ERR_NO_P;
                        end
                        else
                            phase_next = PH_MAGIC_T;
                    end
                    PH_MAGIC_T:
                    begin
                        if (in_byte inside {CH_5, CH_6})
                        begin
                            color_next = (in_byte == CH_6);
                            phase_next = PH_SKIP_W;
                        end
                        else
                        begin
                            emit = 1'b1;
                            err  = ERR_TYPE;
                        end
                    end
                    PH_SKIP_W, PH_SKIP_H, PH_SKIP_M:
                    begin
                        if (!comment_reg && is_hash)
                            comment_next = 1'b1;
                        if (skip_take_num || skip_junk)
                        begin
                            case (phase_reg)
                                PH_SKIP_W:
                                begin
                                    width_next = skip_take_num ? digit_val : '0;
                                    phase_next = skip_take_num ? PH_NUM_W : PH_SKIP_H;
                                end
                                PH_SKIP_H:
                                begin
                                    height_next = skip_take_num ? digit_val : '0;
                                    phase_next  = skip_take_num ? PH_NUM_H : PH_SKIP_M;
                                end
                                default:
                                begin
                                    maxval_next = skip_take_num ? digit_val : '0;
                                    phase_next  = skip_take_num ? PH_NUM_M : PH_TO_EOL;
                                end
                            endcase
                        end
                    end
                    PH_NUM_W, PH_NUM_H:
                    begin
                        if (is_digit)
                        begin
                            if (mac_ovf)
                                ovf_next = 1'b1;
                            if (phase_reg == PH_NUM_W)
                                width_next = mac_val;
                            else
                                height_next = mac_val;
                        end
                        else
                        begin
                            comment_next = is_hash;
                            phase_next   = (phase_reg == PH_NUM_W) ? PH_SKIP_H : PH_SKIP_M;
                        end
                    end
                    PH_NUM_M:
                    begin
                        if (is_digit)
                        begin
                            if (mac_ovf)
                                ovf_next = 1'b1;
                            maxval_next = mac_val;
                        end
                        else if (is_lf)
                            emit = 1'b1;
                        else
                            phase_next = PH_TO_EOL;
                    end
                    PH_TO_EOL:
                    begin
                        if (is_lf)
                            emit = 1'b1;
                    end
                    default:
                    begin
                        phase_next   = PH_MAGIC_P;
                        comment_next = 1'b0;
                        width_next   = '0;
                        height_next  = '0;
                        maxval_next  = '0;
                        color_next   = 1'b0;
                        ovf_next     = 1'b0;
                        count_next   = '0;
                    end
                endcase
            end

            // parser restarts after every result
            if (emit)
            begin
                phase_next   = PH_MAGIC_P;
                comment_next = 1'b0;
                width_next   = '0;
                height_next  = '0;
                maxval_next  = '0;
                color_next   = 1'b0;
                ovf_next     = 1'b0;
                count_next   = '0;
            end
        end
    end

    always_comb
    begin
        res.error_code      = (err == ERR_OK && ovf_reg) ? ERR_OVF : err;
        res.image_width     = width_reg;
        res.image_height    = height_reg;
        res.max_value       = maxval_reg;
        res.plane_count     = color_reg ? 2'd3 : 2'd1;
        res.bytes_per_value = ({1'b0, maxval_reg} >= (DIM_BITS+1)'(TWO_BYTE_MIN)) ?
                              2'd2 : 2'd1;
        res.header_length   = end_of_input ? count_reg : count_inc;
    end

    assign res_valid = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MAGIC_P;
            comment_reg <= 1'b0;
            width_reg   <= '0;
            height_reg  <= '0;
            maxval_reg  <= '0;
            color_reg   <= 1'b0;
            ovf_reg     <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            comment_reg <= comment_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            maxval_reg  <= maxval_next;
            color_reg   <= color_next;
            ovf_reg     <= ovf_next;
            count_reg   <= count_next;
        end
    end

endmodule

### hdl/pnmhp_obuf.sv
// ----------------------------------------------------------------------------
// pnmhp_obuf
// Result register with a skid entry behind it, so a new result can be
// taken while the previous one still waits on a stalled receiver.
// ----------------------------------------------------------------------------
module pnmhp_obuf
    import pnmhp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_res,
    output logic full,
    input  logic out_stall,
    output logic out_valid,
    output res_t out_res
);

    logic out_vld_reg,  out_vld_next;
    logic skid_vld_reg, skid_vld_next;
    res_t out_res_reg,  out_res_next;
    res_t skid_res_reg, skid_res_next;
    logic out_free;

    assign out_free = !out_vld_reg || !out_stall;

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_res_next  = out_res_reg;
        skid_vld_next = skid_vld_reg;
        skid_res_next = skid_res_reg;
        if (out_free)
        begin
            if (skid_vld_reg)
            begin
                out_vld_next  = 1'b1;
                out_res_next  = skid_res_reg;
                skid_vld_next = push;
                skid_res_next = push_res;
            end
            else
            begin
                out_vld_next = push;
                out_res_next = push_res;
            end
        end
        else if (push)
        begin
            skid_vld_next = 1'b1;
            skid_res_next = push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign full      = skid_vld_reg;
    assign out_valid = out_vld_reg;
    assign out_res   = out_res_reg;

endmodule

### hdl/pnm_header_parser.sv
// ----------------------------------------------------------------------------
// pnm_header_parser
// Byte-serial parser for binary PNM (P5/P6) headers.
// ----------------------------------------------------------------------------
// Input channel: one header byte per word (in_byte), or an end-of-stream
// word (end_of_input set, in_byte ignored). Output channel: one result word
// when the header completes or an error is found: error code, width,
// height, maxval, planes, bytes per value and header length.
// Both channels use valid/stall; a word moves on a rising edge with valid
// high and stall low.
// Throughput: one input word per cycle while input is not stalled. Each byte passes through an input
// register and one update of the parse state (a shift-add multiply by ten).
// The word that ends the header passes the input register and the parse state update; its
// result is then registered in the result register, or in the skid entry while earlier results wait.
// Stall: a result register plus one skid entry hold pending results; input
// is stalled only when both are occupied and a word is waiting.
// Reset: all state clears and the parser expects 'P'. It returns to that
// state by itself after every result.
// ----------------------------------------------------------------------------
module pnm_header_parser
    import pnmhp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            in_byte,
    input  logic                  end_of_input,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            error_code,
    output logic [DIM_BITS-1:0]   image_width,
    output logic [DIM_BITS-1:0]   image_height,
    output logic [DIM_BITS-1:0]   max_value,
    output logic [1:0]            plane_count,
    output logic [1:0]            bytes_per_value,
    output logic [COUNT_BITS-1:0] header_length
);

    logic       in_vld_reg;
    logic [7:0] byte_reg;
    logic       eoi_reg;
    logic       full;
    logic       fire;
    logic       res_valid;
    res_t       res;
    res_t       out_res;

    assign fire     = in_vld_reg && !full;
    assign in_stall = in_vld_reg && full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            byte_reg <= in_byte;
            eoi_reg  <= end_of_input;
        end
    end

    pnmhp_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .in_byte      (byte_reg),
        .end_of_input (eoi_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    pnmhp_obuf u_obuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_res  (res),
        .full      (full),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign error_code      = out_res.error_code;
    assign image_width     = out_res.image_width;
    assign image_height    = out_res.image_height;
    assign max_value       = out_res.max_value;
    assign plane_count     = out_res.plane_count;
    assign bytes_per_value = out_res.bytes_per_value;
    assign header_length   = out_res.header_length;

endmodule
